// ===== rtl/bso_pkg.sv =====
package bso_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS + 1;
  localparam int unsigned SUM_BITS   = SQ_BITS + 2;
  localparam int unsigned AXES       = 3;

  localparam logic OP_STORE    = 1'b0;
  localparam logic OP_TEST     = 1'b1;
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_SPHERE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  delta_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;
  typedef logic        [SUM_BITS-1:0]   sum_t;

  typedef coord_t [AXES-1:0] coord3_t;
  typedef delta_t [AXES-1:0] delta3_t;
  typedef sq_t    [AXES-1:0] sq3_t;

  typedef struct packed {
    logic    active;
    logic    kind;
    coord3_t p;
    coord3_t q;
  } collider_t;

  typedef struct packed {
    logic use_dist;
    logic fixed_hit;
  } ctrl_t;

endpackage

// ===== rtl/bso_geom.sv =====
module bso_geom (
  input  bso_pkg::collider_t held_i,
  input  bso_pkg::collider_t item_i,
  output bso_pkg::delta3_t   delta_o,
  output bso_pkg::delta_t    radius_o,
  output bso_pkg::ctrl_t     ctrl_o
);

  bso_pkg::collider_t sph;
  bso_pkg::collider_t bx;
  bso_pkg::coord3_t   clamp;
  bso_pkg::delta3_t   d_sb;
  bso_pkg::delta3_t   d_ss;
  bso_pkg::delta_t    r_sum;
  bso_pkg::delta_t    r_sph;
  logic [bso_pkg::AXES-1:0] bb_ok;

  always_comb begin
    sph = (held_i.kind == bso_pkg::KIND_SPHERE) ? held_i : item_i;
    bx  = (held_i.kind == bso_pkg::KIND_SPHERE) ? item_i : held_i;
    for (int i = 0; i < bso_pkg::AXES; i++) begin
      bb_ok[i] = ($signed(held_i.p[i]) <= $signed(item_i.q[i])) &&
                 ($signed(held_i.q[i]) >= $signed(item_i.p[i]));
      clamp[i] = ($signed(sph.p[i]) < $signed(bx.q[i])) ? sph.p[i] : bx.q[i];
      if ($signed(bx.p[i]) > $signed(clamp[i])) begin
        clamp[i] = bx.p[i];
      end
      d_sb[i] = bso_pkg::delta_t'($signed(clamp[i])) -
                bso_pkg::delta_t'($signed(sph.p[i]));
      d_ss[i] = bso_pkg::delta_t'($signed(held_i.p[i])) -
                bso_pkg::delta_t'($signed(item_i.p[i]));
    end
    r_sum = bso_pkg::delta_t'($signed(held_i.q[0])) +
            bso_pkg::delta_t'($signed(item_i.q[0]));
    r_sph = bso_pkg::delta_t'($signed(sph.q[0]));

    delta_o          = d_sb;
    radius_o         = r_sph;
    ctrl_o.use_dist  = 1'b0;
    ctrl_o.fixed_hit = 1'b0;
    if (held_i.active && item_i.active) begin
      if (held_i.kind == bso_pkg::KIND_BOX && item_i.kind == bso_pkg::KIND_BOX) begin
        ctrl_o.fixed_hit = &bb_ok;
      end else if (held_i.kind == bso_pkg::KIND_SPHERE &&
                   item_i.kind == bso_pkg::KIND_SPHERE) begin
        delta_o         = d_ss;
        radius_o        = r_sum;
        ctrl_o.use_dist = !r_sum[bso_pkg::DIFF_BITS-1] && (r_sum != '0);
      end else begin
        ctrl_o.use_dist = !r_sph[bso_pkg::DIFF_BITS-1] && (r_sph != '0);
      end
    end
  end

endmodule

// ===== rtl/bso_sqr.sv =====
module bso_sqr (
  input  bso_pkg::delta3_t delta_i,
  input  bso_pkg::delta_t  radius_i,
  output bso_pkg::sq3_t    dist_sq_o,
  output bso_pkg::sq_t     radius_sq_o
);

  logic signed [2*bso_pkg::DIFF_BITS-1:0] prod [bso_pkg::AXES];
  logic signed [2*bso_pkg::DIFF_BITS-1:0] prod_r;

  always_comb begin
    for (int i = 0; i < bso_pkg::AXES; i++) begin
      prod[i]      = delta_i[i] * delta_i[i];
      dist_sq_o[i] = prod[i][bso_pkg::SQ_BITS-1:0];
    end
    prod_r      = radius_i * radius_i;
    radius_sq_o = prod_r[bso_pkg::SQ_BITS-1:0];
  end

endmodule

// ===== rtl/box_sphere_overlap_test.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i, in_stall_o   operation_i, active_i, kind_i, p/q x,y,z
// out      output     out_valid_o, out_stall_i hit_o
//
// One item is taken per cycle while in_stall_o is low. A store transfer updates the held
// collider and gives no result. A test transfer's hit passes five register stages:
// input, clamp and differences, squares (the multipliers), sum of squares, result.
// Reset clears the held collider to an inactive box and empties every stage.
// A stall on the output holds every full stage at once; empty stages still fill.
module box_sphere_overlap_test (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic                 active_i,
  input  logic                 kind_i,
  input  logic signed [bso_pkg::COORD_BITS-1:0] p_x_i,
  input  logic signed [bso_pkg::COORD_BITS-1:0] p_y_i,
  input  logic signed [bso_pkg::COORD_BITS-1:0] p_z_i,
  input  logic signed [bso_pkg::COORD_BITS-1:0] q_x_i,
  input  logic signed [bso_pkg::COORD_BITS-1:0] q_y_i,
  input  logic signed [bso_pkg::COORD_BITS-1:0] q_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o
);

  bso_pkg::collider_t item;
  bso_pkg::collider_t held_q;
  bso_pkg::collider_t a1_q;
  bso_pkg::collider_t b1_q;
  bso_pkg::delta3_t   delta_d;
  bso_pkg::delta_t    radius_d;
  bso_pkg::ctrl_t     ctrl_d;
  bso_pkg::delta3_t   delta2_q;
  bso_pkg::delta_t    radius2_q;
  bso_pkg::ctrl_t     ctrl2_q;
  bso_pkg::sq3_t      dist_sq_d;
  bso_pkg::sq_t       radius_sq_d;
  bso_pkg::sq3_t      dist_sq3_q;
  bso_pkg::sq_t       radius_sq3_q;
  bso_pkg::ctrl_t     ctrl3_q;
  bso_pkg::sum_t      sum_d;
  bso_pkg::sum_t      sum4_q;
  bso_pkg::sq_t       radius_sq4_q;
  bso_pkg::ctrl_t     ctrl4_q;
  logic               hit_d;
  logic               hit_q;
  logic               v1_q, v2_q, v3_q, v4_q, vo_q;
  logic               en1, en2, en3, en4, eno;
  logic               accept;

  always_comb begin
    item.active = active_i;
    item.kind   = kind_i;
    item.p[0]   = p_x_i;
    item.p[1]   = p_y_i;
    item.p[2]   = p_z_i;
    item.q[0]   = q_x_i;
    item.q[1]   = q_y_i;
    item.q[2]   = q_z_i;
  end

  assign eno        = !vo_q || !out_stall_i;
  assign en4        = !v4_q || eno;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  bso_geom u_geom (
    .held_i   (a1_q),
    .item_i   (b1_q),
    .delta_o  (delta_d),
    .radius_o (radius_d),
    .ctrl_o   (ctrl_d)
  );

  bso_sqr u_sqr (
    .delta_i     (delta2_q),
    .radius_i    (radius2_q),
    .dist_sq_o   (dist_sq_d),
    .radius_sq_o (radius_sq_d)
  );

  assign sum_d = bso_pkg::sum_t'(dist_sq3_q[0]) + bso_pkg::sum_t'(dist_sq3_q[1]) +
                 bso_pkg::sum_t'(dist_sq3_q[2]);
  assign hit_d = ctrl4_q.use_dist ? (sum4_q < bso_pkg::sum_t'(radius_sq4_q))
                                  : ctrl4_q.fixed_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else begin
      if (accept && operation_i == bso_pkg::OP_STORE) begin
        held_q <= item;
      end
      if (en1) begin
        v1_q <= accept && operation_i == bso_pkg::OP_TEST;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (eno) begin
        vo_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a1_q <= held_q;
      b1_q <= item;
    end
    if (en2) begin
      delta2_q  <= delta_d;
      radius2_q <= radius_d;
      ctrl2_q   <= ctrl_d;
    end
    if (en3) begin
      dist_sq3_q   <= dist_sq_d;
      radius_sq3_q <= radius_sq_d;
      ctrl3_q      <= ctrl2_q;
    end
    if (en4) begin
      sum4_q       <= sum_d;
      radius_sq4_q <= radius_sq3_q;
      ctrl4_q      <= ctrl3_q;
    end
    if (eno) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = vo_q;
  assign hit_o       = hit_q;

endmodule
